>>> hw/rtl/sif_pkg.sv
// Shared types and constants for the set intersection filter.
// Used by sif_cell and set_intersection_filter_top; no dependencies.
`timescale 1ns / 1ps

package sif_pkg;

   // Default number of set entries (one cell per entry)
   localparam int SET_CAPACITY_DEF = 64;

   // Field widths
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 2;

   // Item kinds carried on the input channel
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_PROBE = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // Item travelling down the cell chain
   typedef struct packed {
      logic                       valid;
      action_type                 action;
      logic signed [VALUE_W-1:0]  value;
      logic                       hit;    // value found in the set or stored
   } tok_type;

endpackage

>>> hw/rtl/sif_cell.sv
// One set cell: holds a single entry with its valid bit and passes the
// item on to the next cell through its item register. Depends on sif_pkg.
`timescale 1ns / 1ps

module sif_cell
   import sif_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    shift_en,
   input  tok_type up_tok,
   output tok_type dn_tok
);

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] entry_ff;
   logic                      write_en;
   logic                      eq;
   tok_type                   tok_ff;
   tok_type                   tok_in;

   // Compare, store, or invalidate as the item passes this cell
   always_comb begin
      tok_in   = up_tok;
      valid_in = valid_ff;
      write_en = 1'b0;
      eq       = valid_ff && (entry_ff == up_tok.value);
      if (up_tok.valid) begin
         case (up_tok.action)
            ACT_LOAD: begin
               if (eq) begin
                  tok_in.hit = 1'b1;
               end else if (!valid_ff && !up_tok.hit) begin
                  // first free cell: store a value not seen further up
                  write_en   = 1'b1;
                  valid_in   = 1'b1;
                  tok_in.hit = 1'b1;
               end
            end
            ACT_PROBE: begin
               if (eq) begin
                  tok_in.hit = 1'b1;
               end
            end
            ACT_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the entry, its valid bit and the passing item; advance on shift
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
         if (write_en) begin
            entry_ff <= up_tok.value;
         end
      end
   end

   assign dn_tok = tok_ff;

endmodule

>>> hw/rtl/set_intersection_filter_top.sv
// Set intersection filter: a chain of SET_CAPACITY cells, one entry each.
// An accepted item steps one cell per shift down the chain and then into
// the result register.
// Throughput: one item per cycle while the result side takes results.
// Reset: synchronous; clears all entry valid bits, the chain, the drop flag
// and the result valid bit at once. Depends on sif_pkg and sif_cell.
`timescale 1ns / 1ps

module set_intersection_filter_top
   import sif_pkg::*;
#(
   parameter int SET_CAPACITY = SET_CAPACITY_DEF
)(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] match_value
   output logic [0:0]  rsp_tuser    // [0] incomplete
);

   tok_type                   chain [SET_CAPACITY+1];
   tok_type                   head_tok;
   logic                      shift_en;
   tok_type                   exit_tok;
   logic                      overflow_ff;
   logic                      overflow_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_incomplete_ff;

   // Advance the whole chain whenever the result register can take an item
   assign shift_en   = !rsp_valid_ff || rsp_tready;
   assign req_tready = shift_en;

   // Feed the head of the chain
   always_comb begin
      head_tok.valid  = req_tvalid;
      head_tok.action = action_type'(req_tuser);
      head_tok.value  = req_tdata;
      head_tok.hit    = 1'b0;
   end

   assign chain[0] = head_tok;

   // Row of cells
   for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
      sif_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .up_tok   (chain[i]),
         .dn_tok   (chain[i+1])
      );
   end

   assign exit_tok = chain[SET_CAPACITY];

   // Resolve the item leaving the chain: emit matches, flag dropped loads
   always_comb begin
      overflow_in  = overflow_ff;
      rsp_valid_in = 1'b0;
      if (exit_tok.valid) begin
         case (exit_tok.action)
            ACT_LOAD: begin
               if (!exit_tok.hit) begin
                  overflow_in = 1'b1;
               end
            end
            ACT_PROBE: begin
               rsp_valid_in = exit_tok.hit;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (shift_en) begin
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; the flag reflects drops by earlier items only
   always_ff @(posedge clock) begin
      if (shift_en) begin
         rsp_value_ff      <= exit_tok.value;
         rsp_incomplete_ff <= overflow_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_incomplete_ff;

endmodule
